// ===== design/u8cpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cpd_pkg
// shared types, constants and lead-byte helper for the utf-8 decoder
// ----------------------------------------------------------------------------
package u8cpd_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int FILL_W = 3;
	localparam int WIN_DEPTH = 4;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
	// top five bits of a 16-bit value in the surrogate range
	localparam logic [4:0]      SURR_HI        = 5'b11011;

	// sequence lengths, zero marks an invalid lead
	localparam logic [2:0] LEN_INVALID = 3'd0;
	localparam logic [2:0] LEN_ONE     = 3'd1;
	localparam logic [2:0] LEN_TWO     = 3'd2;
	localparam logic [2:0] LEN_THREE   = 3'd3;
	localparam logic [2:0] LEN_FOUR    = 3'd4;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DECODE
	} state_t;

	typedef struct packed {
		logic load;   // take the accepted byte into the window
		logic emit;   // write one result and consume from the window
	} cmd_t;

	typedef struct packed {
		logic has_result; // front of the window gives a result this cycle
		logic last;       // that result ends the run for this byte
		logic out_free;   // output register can take a result
	} status_t;

	function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
		logic [2:0] len;
		begin
			if (b[7] == 1'b0) begin
				len = LEN_ONE;
			end else if (b[7:5] == 3'b110) begin
				len = LEN_TWO;
			end else if (b[7:4] == 4'b1110) begin
				len = LEN_THREE;
			end else if (b[7:3] == 5'b11110) begin
				len = LEN_FOUR;
			end else begin
				len = LEN_INVALID;
			end
			return len;
		end
	endfunction

endpackage

// ===== design/u8cpd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cpd_ctrl
// controller: accepts one byte, then, while the output is free, steps the window one result per cycle
// ----------------------------------------------------------------------------
module u8cpd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  u8cpd_pkg::status_t  status,
	output u8cpd_pkg::cmd_t     cmd
);

	u8cpd_pkg::state_t state_q;
	u8cpd_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8cpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			u8cpd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = u8cpd_pkg::ST_DECODE;
				end
			end
			u8cpd_pkg::ST_DECODE: begin
				if (!status.has_result) begin
					state_nxt = u8cpd_pkg::ST_IDLE;
				end else if (status.out_free && status.last) begin
					state_nxt = u8cpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = u8cpd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			u8cpd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			u8cpd_pkg::ST_DECODE: begin
				cmd.emit = status.has_result && status.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== design/u8cpd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8cpd_datapath
// byte window, front-of-window decode and output register
// ----------------------------------------------------------------------------
module u8cpd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  u8cpd_pkg::cmd_t                     cmd,
	output u8cpd_pkg::status_t                  status,
	input  logic [u8cpd_pkg::BYTE_W-1:0]        data_byte,
	input  logic                                final_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [u8cpd_pkg::CP_W-1:0]          code_point,
	output logic                                run_last,
	output logic                                string_end
);

	logic [u8cpd_pkg::BYTE_W-1:0] win_q [u8cpd_pkg::WIN_DEPTH];
	logic [u8cpd_pkg::BYTE_W-1:0] win_sh [u8cpd_pkg::WIN_DEPTH];
	logic [u8cpd_pkg::FILL_W-1:0] fill_q;
	logic                         fin_q;
	logic                         out_valid_q;
	logic [u8cpd_pkg::CP_W-1:0]   cp_q;
	logic                         last_q;
	logic                         end_q;

	logic [2:0]                   len;
	logic [2:0]                   nlen;
	logic [u8cpd_pkg::BYTE_W-1:0] lead;
	logic [u8cpd_pkg::BYTE_W-1:0] nlead;
	logic                         c1, c2, c3;
	logic [10:0]                  cp11;
	logic [15:0]                  cp16;
	logic [20:0]                  cp21;
	logic                         seq_ok;
	logic [u8cpd_pkg::CP_W-1:0]   cp_ok;
	logic [u8cpd_pkg::CP_W-1:0]   cp_res;
	logic [2:0]                   consume;
	logic                         clear;
	logic                         has_result;
	logic [u8cpd_pkg::FILL_W-1:0] newfill;
	logic                         last;

	assign lead = win_q[0];
	assign len  = u8cpd_pkg::lead_len(lead);
	assign c1   = (win_q[1][7:6] == 2'b10);
	assign c2   = (win_q[2][7:6] == 2'b10);
	assign c3   = (win_q[3][7:6] == 2'b10);
	assign cp11 = {lead[4:0], win_q[1][5:0]};
	assign cp16 = {lead[3:0], win_q[1][5:0], win_q[2][5:0]};
	assign cp21 = {lead[2:0], win_q[1][5:0], win_q[2][5:0], win_q[3][5:0]};

	// continuation, overlong, surrogate and range checks per length
	always_comb begin
		seq_ok = 1'b0;
		cp_ok  = u8cpd_pkg::REPLACEMENT_CP;
		case (len)
			u8cpd_pkg::LEN_ONE: begin
				seq_ok = 1'b1;
				cp_ok  = {13'd0, lead};
			end
			u8cpd_pkg::LEN_TWO: begin
				seq_ok = c1 && (lead[4:1] != 4'd0);
				cp_ok  = {10'd0, cp11};
			end
			u8cpd_pkg::LEN_THREE: begin
				seq_ok = c1 && c2 && (cp16[15:11] != 5'd0) &&
					(cp16[15:11] != u8cpd_pkg::SURR_HI);
				cp_ok  = {5'd0, cp16};
			end
			u8cpd_pkg::LEN_FOUR: begin
				seq_ok = c1 && c2 && c3 && (cp21[20:16] != 5'd0) &&
					(cp21 <= u8cpd_pkg::MAX_SCALAR);
				cp_ok  = cp21;
			end
			default: begin
				seq_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		has_result = 1'b0;
		consume    = 3'd0;
		clear      = 1'b0;
		cp_res     = u8cpd_pkg::REPLACEMENT_CP;
		if (fill_q == 3'd0) begin
			has_result = 1'b0;
		end else if (len == u8cpd_pkg::LEN_INVALID) begin
			has_result = 1'b1;
			consume    = 3'd1;
		end else if (fill_q < len) begin
			// incomplete: only a flush gives a result
			has_result = fin_q;
			clear      = fin_q;
		end else begin
			has_result = 1'b1;
			consume    = seq_ok ? len : 3'd1;
			cp_res     = seq_ok ? cp_ok : u8cpd_pkg::REPLACEMENT_CP;
		end
	end

	assign newfill = clear ? 3'd0 : (fill_q - consume);

	always_comb begin
		nlead = win_q[0];
		for (int j = 0; j < u8cpd_pkg::WIN_DEPTH; j++) begin
			win_sh[j] = win_q[j];
		end
		case (consume)
			3'd1: begin
				nlead     = win_q[1];
				win_sh[0] = win_q[1];
				win_sh[1] = win_q[2];
				win_sh[2] = win_q[3];
			end
			3'd2: begin
				nlead     = win_q[2];
				win_sh[0] = win_q[2];
				win_sh[1] = win_q[3];
			end
			3'd3: begin
				nlead     = win_q[3];
				win_sh[0] = win_q[3];
			end
			default: begin
				nlead = win_q[0];
			end
		endcase
	end

	assign nlen = u8cpd_pkg::lead_len(nlead);

	// the run ends when the next front gives nothing: empty, or waiting for bytes
	assign last = (newfill == 3'd0) ||
		(!fin_q && (nlen != u8cpd_pkg::LEN_INVALID) && (newfill < nlen));

	assign status.has_result = has_result;
	assign status.last       = last;
	assign status.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= 3'd0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				fill_q <= fill_q + 3'd1;
				fin_q  <= final_byte;
			end else if (cmd.emit) begin
				fill_q <= (last && fin_q) ? 3'd0 : newfill;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[fill_q[1:0]] <= data_byte;
		end else if (cmd.emit) begin
			for (int j = 0; j < u8cpd_pkg::WIN_DEPTH; j++) begin
				win_q[j] <= win_sh[j];
			end
		end
		if (cmd.emit) begin
			cp_q   <= cp_res;
			last_q <= last;
			end_q  <= last && fin_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign run_last   = last_q;
	assign string_end = end_q;

endmodule

// ===== design/utf8_codepoint_decoder_top.sv =====
`timescale 1ns / 1ps
// a byte is written into the window in the idle state; its results are then registered
// from the decode state, and in_stall holds off the next byte until the window waits
// or empties; output stalls hold the decode state
// the front-of-window decoder produces one result per cycle when the output is free
// reset: arst_n clears the window fill, controller state and output valid
// the byte window itself is not cleared, only filled entries are ever read
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_top
// streaming utf-8 decoder, bytes in, unicode code points out
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel, one transfer per byte
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	// code point channel, one transfer per result
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] code_point,
	output logic        run_last,
	output logic        string_end
);

	// command and status between controller and datapath
	u8cpd_pkg::cmd_t    cmd;
	u8cpd_pkg::status_t status;

	// controller: idle takes a byte, decode emits until the window waits or empties
	u8cpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: four-byte window, sequence checks, output register
	// the output register lets a result wait on out_stall while the window holds
	u8cpd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule
